### rtl/cbc_pkg.sv
package cbc_pkg;

    localparam int CTRL_W       = 3;
    localparam int ROM_CNT_W    = 10;
    localparam int RAM_CNT_W    = 5;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int ROM_BANK_W   = 9;
    localparam int RAM_BANK_W   = 4;
    localparam int RTC_IDX_W    = 4;
    localparam int OFFSET_W     = 13;
    localparam int MBC1_BANK_W  = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_COUNT  = 2'd2;

    localparam logic [CTRL_W-1:0] CT_MBC1 = 3'd1;
    localparam logic [CTRL_W-1:0] CT_MBC2 = 3'd2;
    localparam logic [CTRL_W-1:0] CT_MBC3 = 3'd3;
    localparam logic [CTRL_W-1:0] CT_MBC5 = 3'd5;

    localparam logic [CTRL_W-1:0]     CTRL_TYPE_RST  = 3'd0;
    localparam logic [ROM_CNT_W-1:0]  ROM_COUNT_RST  = 10'd2;
    localparam logic [RAM_CNT_W-1:0]  RAM_COUNT_RST  = 5'd1;
    localparam logic [ROM_CNT_W-1:0]  MAX_ROM_BANKS  = 10'd512;

    localparam logic [ADDR_W-1:0]     WINDOW_BASE    = 16'hA000;
    localparam logic [3:0]            ENABLE_CODE    = 4'hA;
    localparam logic [RTC_IDX_W-1:0]  RTC_FIRST      = 4'd8;
    localparam logic [RTC_IDX_W-1:0]  RTC_LAST       = 4'd12;
    localparam logic [3:0]            RAM_CODE_LAST  = 4'd3;

    typedef struct packed {
        logic [CTRL_W-1:0]    ctrl_type;
        logic [ROM_CNT_W-1:0] rom_bank_count;
        logic [RAM_CNT_W-1:0] ram_bank_count;
    } cfg_t;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enabled;
        logic                  rtc_selected;
        logic [RTC_IDX_W-1:0]  rtc_register;
        logic [OFFSET_W-1:0]   ram_offset;
        logic                  latch_strobe;
        logic [DATA_W-1:0]     latch_value;
        logic                  bad_bank;
    } res_t;

endpackage

### rtl/cbc_if.sv
interface cbc_req_if
    import cbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] value;

    modport source (output valid, output func, output address, output value, input ready);
    modport sink   (input valid, input func, input address, input value, output ready);
endinterface

interface cbc_rsp_if
    import cbc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  ram_enabled;
    logic                  rtc_selected;
    logic [RTC_IDX_W-1:0]  rtc_register;
    logic [OFFSET_W-1:0]   ram_offset;
    logic                  latch_strobe;
    logic [DATA_W-1:0]     latch_value;
    logic                  bad_bank;

    modport source (
        output valid, output rom_bank, output ram_bank, output ram_enabled,
        output rtc_selected, output rtc_register, output ram_offset,
        output latch_strobe, output latch_value, output bad_bank,
        input  ready
    );
    modport sink (
        input  valid, input rom_bank, input ram_bank, input ram_enabled,
        input  rtc_selected, input rtc_register, input ram_offset,
        input  latch_strobe, input latch_value, input bad_bank,
        output ready
    );
    modport monitor (
        input  valid, input rom_bank, input ram_bank, input ram_enabled,
        input  rtc_selected, input rtc_register, input ram_offset,
        input  latch_strobe, input latch_value, input bad_bank,
        input  ready
    );
endinterface

### rtl/cbc_cfg_regs.sv
module cbc_cfg_regs
    import cbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CTRL_TYPE: cfg_next.ctrl_type      = cfg_data[CTRL_W-1:0];
                CFG_ROM_COUNT: cfg_next.rom_bank_count = cfg_data[ROM_CNT_W-1:0];
                CFG_RAM_COUNT: cfg_next.ram_bank_count = cfg_data[RAM_CNT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ctrl_type      <= CTRL_TYPE_RST;
            cfg_reg.rom_bank_count <= ROM_COUNT_RST;
            cfg_reg.ram_bank_count <= RAM_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/cbc_mapper.sv
module cbc_mapper
    import cbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              fire,
    input  logic              func,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] value,
    output res_t              res
);

    logic [MBC1_BANK_W-1:0] mbc1_bank_reg,  mbc1_bank_next;
    logic                   mbc1_mode_reg,  mbc1_mode_next;
    logic [ROM_BANK_W-1:0]  mbc5_bank_reg,  mbc5_bank_next;
    logic [ROM_BANK_W-1:0]  rom_bank_reg,   rom_bank_next;
    logic [RAM_BANK_W-1:0]  ram_bank_reg,   ram_bank_next;
    logic                   ram_en_reg,     ram_en_next;
    logic                   rtc_mode_reg,   rtc_mode_next;
    logic [RTC_IDX_W-1:0]   rtc_idx_reg,    rtc_idx_next;

    logic [ROM_CNT_W-1:0]   eff_count;
    logic                   ctrl_write;
    logic [2:0]             region;
    logic                   enable_code;
    logic [4:0]             mbc1_low;
    logic [MBC1_BANK_W-1:0] mbc1_lo_cand;
    logic [MBC1_BANK_W-1:0] mbc1_hi_cand;
    logic [6:0]             mbc3_bank;
    logic [3:0]             code;
    logic [ROM_BANK_W-1:0]  mbc5_cand;
    logic [ADDR_W-1:0]      window_diff;
    logic                   strobe;
    logic [DATA_W-1:0]      lval;
    logic                   bad;

    function automatic logic [MBC1_BANK_W-1:0] mbc1_fix(
        input logic [MBC1_BANK_W-1:0] bank,
        input logic [ROM_CNT_W-1:0]   count
    );
        return ({{(ROM_CNT_W-MBC1_BANK_W){1'b0}}, bank} >= count)
            ? MBC1_BANK_W'(1) : bank;
    endfunction

    assign eff_count    = (cfg.rom_bank_count > MAX_ROM_BANKS) ? MAX_ROM_BANKS
                                                                : cfg.rom_bank_count;
    assign ctrl_write   = !func && !address[ADDR_W-1];
    assign region       = address[14:12];
    assign enable_code  = (value[3:0] == ENABLE_CODE);
    assign mbc1_low     = (value[4:0] == 5'd0) ? 5'd1 : value[4:0];
    assign mbc1_lo_cand = mbc1_fix({mbc1_bank_reg[6:5], mbc1_low}, eff_count);
    assign mbc1_hi_cand = mbc1_fix({value[1:0], mbc1_bank_reg[4:0]}, eff_count);
    assign mbc3_bank    = (value[6:0] == 7'd0) ? 7'd1 : value[6:0];
    assign code         = value[3:0];
    assign mbc5_cand    = region[0] ? {value[0], mbc5_bank_reg[7:0]}
                                    : {mbc5_bank_reg[8], value};
    assign window_diff  = address - WINDOW_BASE;

    always_comb
    begin
        mbc1_bank_next = mbc1_bank_reg;
        mbc1_mode_next = mbc1_mode_reg;
        mbc5_bank_next = mbc5_bank_reg;
        rom_bank_next  = rom_bank_reg;
        ram_bank_next  = ram_bank_reg;
        ram_en_next    = ram_en_reg;
        rtc_mode_next  = rtc_mode_reg;
        rtc_idx_next   = rtc_idx_reg;
        strobe         = 1'b0;
        lval           = '0;
        bad            = 1'b0;
        if (ctrl_write)
        begin
            case (cfg.ctrl_type)
                CT_MBC1:
                begin
                    case (region) inside
                        3'd0, 3'd1: ram_en_next = enable_code;
                        3'd2, 3'd3:
                        begin
                            mbc1_bank_next = mbc1_lo_cand;
                            rom_bank_next  = {2'b00, mbc1_lo_cand};
                        end
                        3'd4, 3'd5:
                        begin
                            if (!mbc1_mode_reg)
                            begin
                                mbc1_bank_next = mbc1_hi_cand;
                                rom_bank_next  = {2'b00, mbc1_hi_cand};
                            end
                            else
                            begin
                                ram_bank_next = {2'b00, value[1:0]};
                            end
                        end
                        default: mbc1_mode_next = value[0];
                    endcase
                end
                CT_MBC2:
                begin
                    case (region) inside
                        3'd0, 3'd1: ram_en_next = !address[8];
                        3'd2, 3'd3:
                        begin
                            if (address[8])
                                rom_bank_next = {5'd0, value[3:0]};
                        end
                        default: ;
                    endcase
                end
                CT_MBC3:
                begin
                    case (region) inside
                        3'd0, 3'd1: ram_en_next = enable_code;
                        3'd2, 3'd3: rom_bank_next = {2'b00, mbc3_bank};
                        3'd4, 3'd5:
                        begin
                            if (code <= RAM_CODE_LAST)
                            begin
                                ram_bank_next = code;
                                rtc_mode_next = 1'b0;
                            end
                            else if (code >= RTC_FIRST && code <= RTC_LAST)
                            begin
                                rtc_idx_next  = code;
                                rtc_mode_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            strobe = 1'b1;
                            lval   = value;
                        end
                    endcase
                end
                CT_MBC5:
                begin
                    case (region) inside
                        3'd0, 3'd1: ram_en_next = enable_code;
                        3'd2, 3'd3:
                        begin
                            mbc5_bank_next = mbc5_cand;
                            rom_bank_next  = mbc5_cand;
                            bad            = ({1'b0, mbc5_cand} >= eff_count);
                        end
                        3'd4, 3'd5:
                        begin
                            if ({1'b0, code} < cfg.ram_bank_count)
                                ram_bank_next = code;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.rom_bank     = rom_bank_next;
        res.ram_bank     = ram_bank_next;
        res.ram_enabled  = ram_en_next;
        res.rtc_selected = (cfg.ctrl_type == CT_MBC3) && rtc_mode_next;
        res.rtc_register = res.rtc_selected ? rtc_idx_next : '0;
        res.ram_offset   = func ? window_diff[OFFSET_W-1:0] : '0;
        res.latch_strobe = strobe;
        res.latch_value  = lval;
        res.bad_bank     = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbc1_bank_reg <= MBC1_BANK_W'(1);
            mbc1_mode_reg <= 1'b0;
            mbc5_bank_reg <= ROM_BANK_W'(1);
            rom_bank_reg  <= ROM_BANK_W'(1);
            ram_bank_reg  <= '0;
            ram_en_reg    <= 1'b0;
            rtc_mode_reg  <= 1'b0;
            rtc_idx_reg   <= RTC_FIRST;
        end
        else if (fire)
        begin
            mbc1_bank_reg <= mbc1_bank_next;
            mbc1_mode_reg <= mbc1_mode_next;
            mbc5_bank_reg <= mbc5_bank_next;
            rom_bank_reg  <= rom_bank_next;
            ram_bank_reg  <= ram_bank_next;
            ram_en_reg    <= ram_en_next;
            rtc_mode_reg  <= rtc_mode_next;
            rtc_idx_reg   <= rtc_idx_next;
        end
    end

endmodule

### rtl/cartridge_bank_controller.sv
// Cartridge bank controller (MBC types 1, 2, 3, 5; other types do no banking).
// req channel: one request per bus access; func 0 is a control write to
//   0x0000-0x7FFF, func 1 is an access to the external window.
// rsp channel: one response per request, in order, with the mapping that holds
//   after the request: ROM/RAM bank, RAM enable, RTC routing, window offset,
//   clock latch strobe and bad-bank flag.
// cfg port: cfg_wr_en/cfg_index/cfg_data set controller type, ROM and RAM bank
//   counts; user writes them only while no request is in flight (unchecked).
// Throughput: one request per cycle when not stalled; the bank decode is a
//   single combinational pass between the request and response registers.
// Stall: while rsp.ready is low the response holds; one more request is taken
//   into the request register, then req.ready drops until rsp drains.
// Reset: ROM bank 1, RAM bank 0, RAM disabled, RTC unmapped with index 8,
//   type 0, ROM count 2, RAM count 1; both channels empty.
module cartridge_bank_controller
    import cbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cbc_req_if.sink               req,
    cbc_rsp_if.source             rsp
);

    cfg_t              cfg;
    res_t              res;

    logic              in_vld_reg, in_vld_next;
    logic              in_func_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_value_reg;
    logic              out_vld_reg, out_vld_next;
    res_t              out_res_reg;
    logic              accept;
    logic              advance;

    cbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbc_mapper u_mapper (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (advance),
        .func    (in_func_reg),
        .address (in_addr_reg),
        .value   (in_value_reg),
        .res     (res)
    );

    assign advance   = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (rsp.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_func_reg  <= req.func;
            in_addr_reg  <= req.address;
            in_value_reg <= req.value;
        end
        if (advance)
            out_res_reg <= res;
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.rom_bank     = out_res_reg.rom_bank;
    assign rsp.ram_bank     = out_res_reg.ram_bank;
    assign rsp.ram_enabled  = out_res_reg.ram_enabled;
    assign rsp.rtc_selected = out_res_reg.rtc_selected;
    assign rsp.rtc_register = out_res_reg.rtc_register;
    assign rsp.ram_offset   = out_res_reg.ram_offset;
    assign rsp.latch_strobe = out_res_reg.latch_strobe;
    assign rsp.latch_value  = out_res_reg.latch_value;
    assign rsp.bad_bank     = out_res_reg.bad_bank;

endmodule

### rtl/cbc_checker.sv
module cbc_checker
    import cbc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    cbc_rsp_if.source rsp
);

    // latch byte only travels with a latch strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.latch_strobe |-> rsp.latch_value == '0)
        else $error("latch_value set without latch_strobe");

    // latch write is a control write, so it carries no window offset
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.latch_strobe |-> rsp.ram_offset == '0 && !rsp.rtc_selected
            || rsp.valid && rsp.latch_strobe && rsp.ram_offset == '0)
        else $error("latch_strobe with window offset");

    // mapped RTC register is one of the clock registers, unmapped reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.rtc_selected && rsp.rtc_register >= RTC_FIRST
                       && rsp.rtc_register <= RTC_LAST)
                   || (!rsp.rtc_selected && rsp.rtc_register == '0))
        else $error("rtc_register inconsistent with rtc_selected");

    // stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.rom_bank)
            && $stable(rsp.ram_bank) && $stable(rsp.ram_offset))
        else $error("response changed while stalled");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .rsp   (rsp)
);

### bench/cartridge_bank_controller_test.sv
`timescale 1ns / 1ps

module cartridge_bank_controller_test;
    import cbc_pkg::*;

    localparam logic FUNC_CTRL   = 1'b0;
    localparam logic FUNC_WINDOW = 1'b1;

    localparam logic [CTRL_W-1:0] CT_NONE  = 3'd0;
    localparam logic [CTRL_W-1:0] CT_SPARE = 3'd4;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 125;

    typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_KNOWN} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  func;
        logic [ADDR_W-1:0]     address;
        logic [DATA_W-1:0]     value;
        logic [CTRL_W-1:0]     ctrl;
        logic [ROM_CNT_W-1:0]  rom_count;
        logic [RAM_CNT_W-1:0]  ram_count;
        res_t                  want;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cbc_req_if req_ch ();
    cbc_rsp_if rsp_ch ();

    cartridge_bank_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // predictor copy of the registers and mapping state
    logic [CTRL_W-1:0]      ctrl_type_cfg;
    logic [ROM_CNT_W-1:0]   rom_count_cfg;
    logic [RAM_CNT_W-1:0]   ram_count_cfg;
    logic [MBC1_BANK_W-1:0] mbc1_bank;
    logic                   mbc1_ram_mode;
    logic [ROM_BANK_W-1:0]  mbc5_bank;
    logic [ROM_BANK_W-1:0]  rom_now;
    logic [RAM_BANK_W-1:0]  ram_now;
    logic                   ram_on;
    logic                   rtc_on;
    logic [RTC_IDX_W-1:0]   rtc_index;

    res_t        pending_maps[$];
    script_row_t script[$];

    int mismatches      = 0;
    int requests_sent   = 0;
    int responses_seen  = 0;
    int settings_used   = 0;
    int max_gap         = 12;
    int max_stall       = 12;
    int rsp_hold_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void mbc1_settle(int unsigned lim);
        if (mbc1_bank >= lim)
            mbc1_bank = 1;
        rom_now = ROM_BANK_W'(mbc1_bank);
    endfunction

    function automatic res_t map_after_request(logic f, logic [ADDR_W-1:0] a,
                                               logic [DATA_W-1:0] v);
        res_t              r;
        logic [3:0]        region;
        logic [4:0]        low5;
        logic [6:0]        b7;
        logic [3:0]        code;
        logic [ADDR_W-1:0] delta;
        int unsigned       lim;
        r = '0;
        region = a[15:12];
        lim = (rom_count_cfg > MAX_ROM_BANKS) ? MAX_ROM_BANKS : rom_count_cfg;
        if (f == FUNC_CTRL && !a[15])
        begin
            case (ctrl_type_cfg)
                CT_MBC1:
                begin
                    if (region < 2)
                        ram_on = (v[3:0] == ENABLE_CODE);
                    else if (region < 4)
                    begin
                        low5 = v[4:0];
                        if (low5 == 0)
                            low5 = 1;
                        mbc1_bank = {mbc1_bank[6:5], low5};
                        mbc1_settle(lim);
                    end
                    else if (region < 6)
                    begin
                        if (!mbc1_ram_mode)
                        begin
                            mbc1_bank = {v[1:0], mbc1_bank[4:0]};
                            mbc1_settle(lim);
                        end
                        else
                            ram_now = RAM_BANK_W'(v[1:0]);
                    end
                    else
                        mbc1_ram_mode = v[0];
                end
                CT_MBC2:
                begin
                    if (region < 2)
                        ram_on = !a[8];
                    else if (region < 4 && a[8])
                        rom_now = ROM_BANK_W'(v[3:0]);
                end
                CT_MBC3:
                begin
                    if (region < 2)
                        ram_on = (v[3:0] == ENABLE_CODE);
                    else if (region < 4)
                    begin
                        b7 = v[6:0];
                        rom_now = (b7 == 0) ? ROM_BANK_W'(1) : ROM_BANK_W'(b7);
                    end
                    else if (region < 6)
                    begin
                        code = v[3:0];
                        if (code <= RAM_CODE_LAST)
                        begin
                            ram_now = code;
                            rtc_on = 1'b0;
                        end
                        else if (code >= RTC_FIRST && code <= RTC_LAST)
                        begin
                            rtc_index = code;
                            rtc_on = 1'b1;
                        end
                    end
                    else
                    begin
                        r.latch_strobe = 1'b1;
                        r.latch_value = v;
                    end
                end
                CT_MBC5:
                begin
                    if (region < 2)
                        ram_on = (v[3:0] == ENABLE_CODE);
                    else if (region < 4)
                    begin
                        if (region == 2)
                            mbc5_bank = {mbc5_bank[8], v};
                        else
                            mbc5_bank = {v[0], mbc5_bank[7:0]};
                        r.bad_bank = (mbc5_bank >= lim);
                        rom_now = mbc5_bank;
                    end
                    else if (region < 6 && v[3:0] < ram_count_cfg)
                        ram_now = v[3:0];
                end
                default: ;
            endcase
        end
        else if (f == FUNC_WINDOW)
        begin
            delta = a - WINDOW_BASE;
            r.ram_offset = delta[OFFSET_W-1:0];
        end
        r.rom_bank = rom_now;
        r.ram_bank = ram_now;
        r.ram_enabled = ram_on;
        r.rtc_selected = (ctrl_type_cfg == CT_MBC3) && rtc_on;
        r.rtc_register = r.rtc_selected ? rtc_index : '0;
        return r;
    endfunction

    function automatic res_t mapping(int rom, int ram, bit en, bit rsel, int rreg,
                                     int off, bit stb, int lval, bit bad);
        res_t r;
        r.rom_bank = ROM_BANK_W'(rom);
        r.ram_bank = RAM_BANK_W'(ram);
        r.ram_enabled = en;
        r.rtc_selected = rsel;
        r.rtc_register = RTC_IDX_W'(rreg);
        r.ram_offset = OFFSET_W'(off);
        r.latch_strobe = stb;
        r.latch_value = DATA_W'(lval);
        r.bad_bank = bad;
        return r;
    endfunction

    function automatic script_row_t req_row(logic f, logic [ADDR_W-1:0] a,
                                            logic [DATA_W-1:0] v);
        script_row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.func = f;
        r.address = a;
        r.value = v;
        return r;
    endfunction

    function automatic script_row_t known_row(logic f, logic [ADDR_W-1:0] a,
                                              logic [DATA_W-1:0] v, res_t want);
        script_row_t r;
        r = req_row(f, a, v);
        r.kind = ROW_KNOWN;
        r.want = want;
        return r;
    endfunction

    function automatic script_row_t cfg_row(logic [CTRL_W-1:0] ct,
                                            logic [ROM_CNT_W-1:0] romc,
                                            logic [RAM_CNT_W-1:0] ramc);
        script_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.ctrl = ct;
        r.rom_count = romc;
        r.ram_count = ramc;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_request(logic f, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] v,
                                bit known, res_t want);
        int   gap;
        res_t predicted;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.address <= a;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = map_after_request(f, a, v);
        pending_maps.push_back(known ? want : predicted);
        requests_sent++;
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic configure(logic [CTRL_W-1:0] ct, logic [ROM_CNT_W-1:0] romc,
                             logic [RAM_CNT_W-1:0] ramc);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CTRL_TYPE;
        cfg_data <= CFG_DATA_W'(ct);
        @(posedge clk);
        cfg_index <= CFG_ROM_COUNT;
        cfg_data <= CFG_DATA_W'(romc);
        @(posedge clk);
        cfg_index <= CFG_RAM_COUNT;
        cfg_data <= CFG_DATA_W'(ramc);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ctrl_type_cfg = ct;
        rom_count_cfg = romc;
        ram_count_cfg = ramc;
        settings_used++;
        @(posedge clk);
    endtask

    // response side: random stalls per response, plus an optional long hold
    initial
    begin
        int   stall_left;
        res_t expected;
        res_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.rom_bank = rsp_ch.rom_bank;
                got.ram_bank = rsp_ch.ram_bank;
                got.ram_enabled = rsp_ch.ram_enabled;
                got.rtc_selected = rsp_ch.rtc_selected;
                got.rtc_register = rsp_ch.rtc_register;
                got.ram_offset = rsp_ch.ram_offset;
                got.latch_strobe = rsp_ch.latch_strobe;
                got.latch_value = rsp_ch.latch_value;
                got.bad_bank = rsp_ch.bad_bank;
                if (pending_maps.size() == 0)
                begin
                    $error("response with no request pending");
                    mismatches++;
                end
                else
                begin
                    expected = pending_maps.pop_front();
                    check_field("rom_bank", expected.rom_bank, got.rom_bank);
                    check_field("ram_bank", expected.ram_bank, got.ram_bank);
                    check_field("ram_enabled", expected.ram_enabled, got.ram_enabled);
                    check_field("rtc_selected", expected.rtc_selected, got.rtc_selected);
                    check_field("rtc_register", expected.rtc_register, got.rtc_register);
                    check_field("ram_offset", expected.ram_offset, got.ram_offset);
                    check_field("latch_strobe", expected.latch_strobe, got.latch_strobe);
                    check_field("latch_value", expected.latch_value, got.latch_value);
                    check_field("bad_bank", expected.bad_bank, got.bad_bank);
                end
                responses_seen++;
                stall_left = (max_stall == 0) ? 0 : $urandom_range(0, max_stall);
            end
            if (rsp_hold_cycles > 0)
            begin
                rsp_hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int                   phase;
        int                   n;
        int                   pick;
        int                   waited;
        logic                 f;
        logic [ADDR_W-1:0]    a;
        logic [DATA_W-1:0]    v;
        logic [CTRL_W-1:0]    ct;
        logic [ROM_CNT_W-1:0] romc;
        logic [RAM_CNT_W-1:0] ramc;

        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.func <= 1'b0;
        req_ch.address <= '0;
        req_ch.value <= '0;
        rsp_ch.ready <= 1'b0;

        ctrl_type_cfg = CTRL_TYPE_RST;
        rom_count_cfg = ROM_COUNT_RST;
        ram_count_cfg = RAM_COUNT_RST;
        mbc1_bank = 1;
        mbc1_ram_mode = 1'b0;
        mbc5_bank = 1;
        rom_now = 1;
        ram_now = 0;
        ram_on = 1'b0;
        rtc_on = 1'b0;
        rtc_index = RTC_FIRST;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset mapping, each controller, range and error corners
        script.push_back(known_row(FUNC_WINDOW, 16'hA000, 8'h00,
                                   mapping(1, 0, 0, 0, 0, 0, 0, 0, 0)));
        script.push_back(known_row(FUNC_WINDOW, 16'hFFFF, 8'hFF,
                                   mapping(1, 0, 0, 0, 0, 13'h1FFF, 0, 0, 0)));
        script.push_back(cfg_row(CT_MBC1, 10'd512, 5'd4));
        script.push_back(req_row(FUNC_CTRL, 16'h0000, 8'h0A));
        script.push_back(req_row(FUNC_CTRL, 16'h2000, 8'h00));
        script.push_back(req_row(FUNC_CTRL, 16'h3FFF, 8'hFF));
        script.push_back(known_row(FUNC_CTRL, 16'h4000, 8'h03,
                                   mapping(127, 0, 1, 0, 0, 0, 0, 0, 0)));
        script.push_back(req_row(FUNC_CTRL, 16'h6000, 8'h01));
        script.push_back(req_row(FUNC_CTRL, 16'h5FFF, 8'hFF));
        script.push_back(req_row(FUNC_CTRL, 16'h8000, 8'h00));
        script.push_back(known_row(FUNC_WINDOW, 16'hBFFF, 8'h00,
                                   mapping(127, 3, 1, 0, 0, 13'h1FFF, 0, 0, 0)));
        script.push_back(cfg_row(CT_MBC1, 10'd1, 5'd4));
        script.push_back(req_row(FUNC_CTRL, 16'h2000, 8'h05));
        script.push_back(cfg_row(CT_MBC2, 10'd16, 5'd1));
        script.push_back(req_row(FUNC_CTRL, 16'h0000, 8'h00));
        script.push_back(req_row(FUNC_CTRL, 16'h2100, 8'hFE));
        script.push_back(req_row(FUNC_CTRL, 16'h2000, 8'h07));
        script.push_back(req_row(FUNC_CTRL, 16'h4000, 8'h01));
        script.push_back(req_row(FUNC_CTRL, 16'h0100, 8'h0A));
        script.push_back(cfg_row(CT_MBC3, 10'd128, 5'd4));
        script.push_back(req_row(FUNC_CTRL, 16'h0000, 8'hFA));
        script.push_back(req_row(FUNC_CTRL, 16'h2000, 8'h80));
        script.push_back(known_row(FUNC_CTRL, 16'h4000, 8'h0C,
                                   mapping(1, 3, 1, 1, 12, 0, 0, 0, 0)));
        script.push_back(req_row(FUNC_CTRL, 16'h4000, 8'h05));
        script.push_back(known_row(FUNC_CTRL, 16'h7FFF, 8'hFF,
                                   mapping(1, 3, 1, 1, 12, 0, 1, 8'hFF, 0)));
        script.push_back(req_row(FUNC_CTRL, 16'h4000, 8'h02));
        script.push_back(cfg_row(CT_MBC5, 10'd512, 5'd16));
        script.push_back(req_row(FUNC_CTRL, 16'h2000, 8'hFF));
        script.push_back(known_row(FUNC_CTRL, 16'h3000, 8'h01,
                                   mapping(511, 2, 1, 0, 0, 0, 0, 0, 0)));
        script.push_back(cfg_row(CT_MBC5, 10'd256, 5'd16));
        script.push_back(known_row(FUNC_CTRL, 16'h2000, 8'h00,
                                   mapping(256, 2, 1, 0, 0, 0, 0, 0, 1)));
        script.push_back(req_row(FUNC_CTRL, 16'h4000, 8'h0F));
        script.push_back(cfg_row(CT_MBC5, 10'd256, 5'd0));
        script.push_back(req_row(FUNC_CTRL, 16'h5000, 8'h01));
        script.push_back(req_row(FUNC_CTRL, 16'h6000, 8'h55));
        script.push_back(cfg_row(CT_SPARE, 10'd2, 5'd1));
        script.push_back(req_row(FUNC_CTRL, 16'h2000, 8'h03));

        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_CFG:
                    configure(script[i].ctrl, script[i].rom_count, script[i].ram_count);
                ROW_KNOWN:
                    send_request(script[i].func, script[i].address, script[i].value,
                                 1'b1, script[i].want);
                default:
                    send_request(script[i].func, script[i].address, script[i].value,
                                 1'b0, '0);
            endcase
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 6)
                0: ct = CT_MBC1;
                1: ct = CT_MBC3;
                2: ct = CT_MBC5;
                3: ct = CT_MBC2;
                4: ct = (phase < 6) ? CT_NONE : CT_SPARE;
                default: ct = 3'($urandom_range(0, 5));
            endcase
            case ($urandom_range(0, 5))
                0: romc = 10'd1;
                1: romc = 10'd512;
                2: romc = 10'd2;
                default: romc = 10'($urandom_range(1, 512));
            endcase
            case ($urandom_range(0, 3))
                0: ramc = 5'd0;
                1: ramc = 5'd16;
                default: ramc = 5'($urandom_range(0, 16));
            endcase
            configure(ct, romc, ramc);
            max_gap = (phase % 3 == 1) ? 0 : 12;
            max_stall = (phase % 3 == 1) ? 0 : 12;
            if (phase == 2)
            begin
                // response side stalls long while requests keep coming
                max_gap = 0;
                rsp_hold_cycles = 150;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    f = FUNC_CTRL;
                    a = 16'($urandom_range(0, 16'h7FFF));
                    case ($urandom_range(0, 3))
                        0: v = {4'($urandom), ENABLE_CODE};
                        1: v = {4'($urandom), 4'($urandom_range(0, 12))};
                        default: v = 8'($urandom);
                    endcase
                end
                else if (pick < 90)
                begin
                    f = FUNC_WINDOW;
                    a = WINDOW_BASE + 16'($urandom_range(0, 16'h1FFF));
                    v = 8'($urandom);
                end
                else
                begin
                    f = 1'($urandom);
                    a = 16'($urandom);
                    v = 8'($urandom);
                end
                send_request(f, a, v, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_maps.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_maps.size() != 0)
        begin
            $error("%0d responses never arrived", pending_maps.size());
            mismatches++;
        end
        repeat (10) @(posedge clk);

        $display("Covered %0d requests under %0d controller settings, %0d responses checked.",
                 requests_sent, settings_used, responses_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/cbc_pkg.sv
rtl/cbc_if.sv
rtl/cbc_cfg_regs.sv
rtl/cbc_mapper.sv
rtl/cartridge_bank_controller.sv
rtl/cbc_checker.sv
bench/cartridge_bank_controller_test.sv
